/* rtl/core/single_wire_sensor_frame_decoder_top_assert.svh */
// Assertion macros used by the frame decoder checker.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_TOP_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWSFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frame decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frame decoder assertion failed");

`endif

/* rtl/core/swsfd_pkg.sv */
// Types, constants and request codes of the single-wire sensor frame decoder.
package swsfd_pkg;

  localparam int TIME_WIDTH_DEFAULT = 32;
  localparam int TIME_FIELD_W       = 32;
  localparam int THRESH_W           = 10;
  localparam int COUNT_W            = 6;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd100;

  localparam logic [COUNT_W-1:0] FIRST_DATA_EDGE  = 6'd2;
  localparam logic [COUNT_W-1:0] LAST_DATA_SHIFT  = 6'd33;
  localparam logic [COUNT_W-1:0] FIRST_CHECK_EDGE = 6'd34;
  localparam logic [COUNT_W-1:0] LAST_CHECK_SHIFT = 6'd41;
  localparam logic [COUNT_W-1:0] FRAME_EDGES      = 6'd42;

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_EDGE   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CORRUPTED = 2'd1;
  localparam logic [1:0] STATUS_NO_SENSOR = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [TIME_FIELD_W-1:0] edge_time_us;
  } in_item_t;

  typedef struct packed {
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temperature_int;
    logic [7:0] temperature_frac;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } frame_result_t;

endpackage

/* rtl/core/swsfd_in_stage.sv */
// Input register stage: holds one request until the frame logic consumes it.
module swsfd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swsfd_pkg::in_item_t in_item,
  input  logic                consume,
  output logic                req_valid,
  output swsfd_pkg::in_item_t req_item
);

  logic                valid_r;
  logic                valid_nxt;
  swsfd_pkg::in_item_t item_r;

  // The stage can take a request when empty or when its request leaves this cycle.
  assign in_ready  = rst_n && (!valid_r || consume);
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign req_valid = valid_r;
  assign req_item  = item_r;

endmodule

/* rtl/core/swsfd_frame_logic.sv */
// Frame state and the per-request decode step of the sensor reply.
module swsfd_frame_logic #(
  parameter int TIME_WIDTH = swsfd_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [swsfd_pkg::THRESH_W-1:0]     cfg_data,
  input  logic                               step,
  input  swsfd_pkg::in_item_t                req_item,
  output swsfd_pkg::frame_result_t           result
);

  logic [swsfd_pkg::THRESH_W-1:0] thresh_r;
  logic [TIME_WIDTH-1:0]          last_edge_r, last_edge_nxt;
  logic [swsfd_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [31:0]                    data_r, data_nxt;
  logic [7:0]                     check_r, check_nxt;
  logic                           reported_r, reported_nxt;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] interval;
  logic                  is_one;
  logic [4:0]            data_idx;
  logic [2:0]            check_idx;
  logic                  emit;
  logic [7:0]            byte_sum;
  logic [1:0]            status;

  assign now       = TIME_WIDTH'(req_item.edge_time_us);
  assign interval  = now - last_edge_r;
  assign is_one    = interval > TIME_WIDTH'(thresh_r);
  assign data_idx  = 5'(swsfd_pkg::LAST_DATA_SHIFT - count_r);
  assign check_idx = 3'(swsfd_pkg::LAST_CHECK_SHIFT - count_r);

  always_comb begin
    last_edge_nxt = last_edge_r;
    count_nxt     = count_r;
    data_nxt      = data_r;
    check_nxt     = check_r;
    reported_nxt  = reported_r;
    emit          = 1'b0;
    case (req_item.req_type)
      swsfd_pkg::REQ_START: begin
        last_edge_nxt = '0;
        count_nxt     = '0;
        data_nxt      = '0;
        check_nxt     = '0;
        reported_nxt  = 1'b0;
      end
      swsfd_pkg::REQ_EDGE: begin
        if (!reported_r && count_r < swsfd_pkg::FRAME_EDGES) begin
          last_edge_nxt = now;
          if (is_one) begin
            if (count_r inside {[swsfd_pkg::FIRST_DATA_EDGE:swsfd_pkg::LAST_DATA_SHIFT]}) begin
              data_nxt[data_idx] = 1'b1;
            end else if (count_r >= swsfd_pkg::FIRST_CHECK_EDGE) begin
              check_nxt[check_idx] = 1'b1;
            end
          end
          count_nxt = count_r + 6'd1;
          if (count_nxt == swsfd_pkg::FRAME_EDGES) begin
            emit = 1'b1;
          end
        end
      end
      swsfd_pkg::REQ_FINISH: begin
        if (!reported_r) begin
          emit = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      reported_nxt = 1'b1;
    end
  end

  // The report is built from the state as it stands after this request.
  assign byte_sum = data_nxt[31:24] + data_nxt[23:16] + data_nxt[15:8] + data_nxt[7:0];

  always_comb begin
    if (check_nxt != byte_sum) begin
      status = swsfd_pkg::STATUS_CORRUPTED;
    end else if (count_nxt != '0) begin
      status = swsfd_pkg::STATUS_OK;
    end else begin
      status = swsfd_pkg::STATUS_NO_SENSOR;
    end
  end

  always_comb begin
    result.emit                  = emit;
    result.item.status           = status;
    if (status == swsfd_pkg::STATUS_OK) begin
      result.item.humidity_int     = data_nxt[31:24];
      result.item.humidity_frac    = data_nxt[23:16];
      result.item.temperature_int  = data_nxt[15:8];
      result.item.temperature_frac = data_nxt[7:0];
    end else begin
      result.item.humidity_int     = '0;
      result.item.humidity_frac    = '0;
      result.item.temperature_int  = '0;
      result.item.temperature_frac = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= swsfd_pkg::THRESH_RESET;
      last_edge_r <= '0;
      count_r     <= '0;
      data_r      <= '0;
      check_r     <= '0;
      reported_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_data;
      end
      if (step) begin
        last_edge_r <= last_edge_nxt;
        count_r     <= count_nxt;
        data_r      <= data_nxt;
        check_r     <= check_nxt;
        reported_r  <= reported_nxt;
      end
    end
  end

endmodule

/* rtl/core/swsfd_out_stage.sv */
// Result register: holds one report until the consumer takes it.
module swsfd_out_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  swsfd_pkg::frame_result_t result,
  output logic                     has_room,
  output logic                     out_valid,
  input  logic                     out_ready,
  output swsfd_pkg::out_item_t     out_item
);

  logic                 valid_r;
  logic                 valid_nxt;
  logic                 load;
  swsfd_pkg::out_item_t item_r;

  assign has_room  = !valid_r || out_ready;
  assign load      = step && result.emit;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result.item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* rtl/core/single_wire_sensor_frame_decoder_top.sv */
// The report of a frame passes the request register and then the result register.
// Throughput: one request per cycle while the result register has room; the edge step is a single
// subtract, compare and bit set. The request register and the result register are decoupled, so a
// stalled report does not block intake until the request register is also full.
// Reset (synchronous, active low) clears the frame state and sets the threshold to 100 us.
module single_wire_sensor_frame_decoder_top #(
  parameter int TIME_WIDTH = swsfd_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  swsfd_pkg::in_item_t            in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output swsfd_pkg::out_item_t           out_item,
  input  logic                           cfg_we,
  input  logic [swsfd_pkg::THRESH_W-1:0] cfg_data
);

  logic                     req_valid;
  swsfd_pkg::in_item_t      req_item;
  logic                     has_room;
  logic                     step;
  swsfd_pkg::frame_result_t result;

  assign step = req_valid && has_room;

  swsfd_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .consume   (step),
    .req_valid (req_valid),
    .req_item  (req_item)
  );

  swsfd_frame_logic #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_frame_logic (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (step),
    .req_item (req_item),
    .result   (result)
  );

  swsfd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .result    (result),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* rtl/core/swsfd_checker.sv */
// Port-level checker for the frame decoder and its bind to the top level.
`include "single_wire_sensor_frame_decoder_top_assert.svh"

module swsfd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input swsfd_pkg::out_item_t out_item
);

  // A waiting report stays valid and unchanged.
  `SWSFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SWSFD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_item))

  // Only a good frame carries its bytes.
  `SWSFD_ASSERT_IMPLY(a_bytes_zero, clk, rst_n,
    out_valid && out_item.status != swsfd_pkg::STATUS_OK,
    out_item.humidity_int == 8'd0 && out_item.humidity_frac == 8'd0 &&
    out_item.temperature_int == 8'd0 && out_item.temperature_frac == 8'd0)

  // A new report follows an accepted request through the request register and the result register.
  `SWSFD_ASSERT_IMPLY(a_report_latency, clk, rst_n, $rose(out_valid),
    $past(in_valid && in_ready, 2))

endmodule

bind single_wire_sensor_frame_decoder_top swsfd_checker u_swsfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
